### design/ufk_pkg.sv
// ---------------------------------------------------------------------------
// ufk_pkg
// shared types and constants of the kruskal edge filter
// ---------------------------------------------------------------------------
package ufk_pkg;

  localparam int VTX_W    = 10;
  localparam int WEIGHT_W = 16;
  localparam int COST_W   = 32;
  localparam int RANK_W   = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
  localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

  typedef struct packed {
    logic                       start_new;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic [VTX_W-1:0]           first_vertex;
    logic [VTX_W-1:0]           second_vertex;
  } in_word_t;

  typedef struct packed {
    logic                     edge_taken;
    logic signed [COST_W-1:0] tree_cost;
  } out_word_t;

endpackage

### design/ufk_ram.sv
// ---------------------------------------------------------------------------
// ufk_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module ufk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### design/ufk_cost.sv
// ---------------------------------------------------------------------------
// ufk_cost
// running tree cost with signed saturating add
// ---------------------------------------------------------------------------
module ufk_cost (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 clear,
  input  logic                                 add_en,
  input  logic signed [ufk_pkg::WEIGHT_W-1:0]  weight,
  output logic signed [ufk_pkg::COST_W-1:0]    cost,
  output logic signed [ufk_pkg::COST_W-1:0]    cost_sum
);

  logic signed [ufk_pkg::COST_W-1:0] cost_r;
  logic signed [ufk_pkg::COST_W-1:0] cost_nxt;
  logic signed [ufk_pkg::COST_W:0]   wide_sum;

  // one extra bit catches overflow
  assign wide_sum = {cost_r[ufk_pkg::COST_W-1], cost_r}
                  + (ufk_pkg::COST_W+1)'(weight);

  always_comb begin
    if (wide_sum[ufk_pkg::COST_W] != wide_sum[ufk_pkg::COST_W-1]) begin
      cost_sum = wide_sum[ufk_pkg::COST_W] ? ufk_pkg::COST_MIN : ufk_pkg::COST_MAX;
    end else begin
      cost_sum = wide_sum[ufk_pkg::COST_W-1:0];
    end
  end

  always_comb begin
    cost_nxt = cost_r;
    if (clear) begin
      cost_nxt = '0;
    end else if (add_en) begin
      cost_nxt = cost_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= '0;
    end else begin
      cost_r <= cost_nxt;
    end
  end

  assign cost = cost_r;

endmodule

### design/union_find_kruskal_edge_filter.sv
// ---------------------------------------------------------------------------
// union_find_kruskal_edge_filter
// kruskal edge filter over a disjoint-set forest with rank union and path
// compression; one edge word in, one result word out
//
// order: from accept, a root walk and a path compression for the first endpoint,
//   then for the second, then the rank states S_RANK_A and S_RANK_B before the
//   strobe of a taken edge; an edge inside one set is strobed without the rank
//   states, and an out-of-range edge is strobed from S_BEGIN without any walk
// throughput: one edge at a time, start is taken again in the strobe cycle
// a start_new edge first runs a clearing sweep over every vertex
// reset: synchronous, runs the same sweep with busy high;
//   results are strobed for one cycle and cannot be held off
// ---------------------------------------------------------------------------
module union_find_kruskal_edge_filter #(
  parameter int VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ufk_pkg::in_word_t  in_data,
  output logic               out_valid,
  output ufk_pkg::out_word_t out_data
);

  localparam int IDXW = $clog2(VERTICES);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(VERTICES - 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_BEGIN  = 3'd2;
  localparam logic [2:0] S_ROOT   = 3'd3;
  localparam logic [2:0] S_COMP   = 3'd4;
  localparam logic [2:0] S_RANK_A = 3'd5;
  localparam logic [2:0] S_RANK_B = 3'd6;
  localparam logic [2:0] S_SPARE  = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [IDXW-1:0]         cnt_r, cnt_nxt;
  logic                    pending_r, pending_nxt;
  logic                    which_r, which_nxt;
  logic [IDXW-1:0]         cur_r, cur_nxt;
  logic [IDXW-1:0]         root_r, root_nxt;
  logic [IDXW-1:0]         ra_r, ra_nxt;
  logic [ufk_pkg::RANK_W-1:0] rank_a_r, rank_a_nxt;
  ufk_pkg::in_word_t       item_r, item_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ufk_pkg::out_word_t      out_data_r, out_data_nxt;

  // parent and rank ram ports
  logic                       p_we;
  logic [IDXW-1:0]            p_waddr, p_wdata, p_raddr, p_rdata;
  logic                       r_we;
  logic [IDXW-1:0]            r_waddr, r_raddr;
  logic [ufk_pkg::RANK_W-1:0] r_wdata, r_rdata;

  // cost unit
  logic                              cost_clear, cost_add;
  logic signed [ufk_pkg::COST_W-1:0] cost_cur, cost_sum;

  // shared link compare
  logic [IDXW-1:0] cmp_ref;
  logic            link_hit;

  logic            accept;
  logic            in_range;
  logic [IDXW-1:0] idx_a, idx_b;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // endpoints checked against the forest size before indexing
  assign in_range = (32'(item_r.first_vertex) < 32'(VERTICES))
                 && (32'(item_r.second_vertex) < 32'(VERTICES));
  assign idx_a = IDXW'(item_r.first_vertex);
  assign idx_b = IDXW'(item_r.second_vertex);

  // root walk stops on a self link, compression stops on a link to the root
  assign cmp_ref  = (state_r == S_ROOT) ? cur_r : root_r;
  assign link_hit = (p_rdata == cmp_ref);

  ufk_ram #(
    .WIDTH (IDXW),
    .DEPTH (VERTICES)
  ) u_parent (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  ufk_ram #(
    .WIDTH (ufk_pkg::RANK_W),
    .DEPTH (VERTICES)
  ) u_rank (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  ufk_cost u_cost (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cost_clear),
    .add_en   (cost_add),
    .weight   (item_r.edge_weight),
    .cost     (cost_cur),
    .cost_sum (cost_sum)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pending_nxt   = pending_r;
    which_nxt     = which_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    ra_nxt        = ra_r;
    rank_a_nxt    = rank_a_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    p_we    = 1'b0;
    p_waddr = cur_r;
    p_wdata = root_r;
    p_raddr = cur_r;
    r_we    = 1'b0;
    r_waddr = root_r;
    r_wdata = '0;
    r_raddr = root_r;

    cost_clear = 1'b0;
    cost_add   = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        // sweep: every vertex its own root with rank zero
        p_we    = 1'b1;
        p_waddr = cnt_r;
        p_wdata = cnt_r;
        r_we    = 1'b1;
        r_waddr = cnt_r;
        r_wdata = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt     = '0;
          pending_nxt = 1'b0;
          state_nxt   = pending_r ? S_BEGIN : S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          if (in_data.start_new) begin
            cost_clear  = 1'b1;
            pending_nxt = 1'b1;
            state_nxt   = S_CLEAR;
          end else begin
            state_nxt = S_BEGIN;
          end
        end
      end

      S_BEGIN: begin
        if (!in_range) begin
          // out-of-range edge leaves forest and cost alone
          out_valid_nxt           = 1'b1;
          out_data_nxt.edge_taken = 1'b0;
          out_data_nxt.tree_cost  = cost_cur;
          state_nxt               = S_IDLE;
        end else begin
          which_nxt = 1'b0;
          p_raddr   = idx_a;
          cur_nxt   = idx_a;
          state_nxt = S_ROOT;
        end
      end

      S_ROOT: begin
        if (link_hit) begin
          root_nxt  = cur_r;
          p_raddr   = which_r ? idx_b : idx_a;
          cur_nxt   = which_r ? idx_b : idx_a;
          state_nxt = S_COMP;
        end else begin
          p_raddr = p_rdata;
          cur_nxt = p_rdata;
        end
      end

      S_COMP: begin
        if (link_hit) begin
          if (!which_r) begin
            // first root done, walk the second endpoint
            ra_nxt    = root_r;
            which_nxt = 1'b1;
            p_raddr   = idx_b;
            cur_nxt   = idx_b;
            state_nxt = S_ROOT;
          end else if (ra_r == root_r) begin
            // same set, edge dropped
            out_valid_nxt           = 1'b1;
            out_data_nxt.edge_taken = 1'b0;
            out_data_nxt.tree_cost  = cost_cur;
            state_nxt               = S_IDLE;
          end else begin
            r_raddr   = ra_r;
            state_nxt = S_RANK_A;
          end
        end else begin
          // point this vertex straight at the root and move on
          p_we      = 1'b1;
          p_waddr   = cur_r;
          p_wdata   = root_r;
          p_raddr   = p_rdata;
          cur_nxt   = p_rdata;
        end
      end

      S_RANK_A: begin
        rank_a_nxt = r_rdata;
        r_raddr    = root_r;
        state_nxt  = S_RANK_B;
      end

      S_RANK_B: begin
        // root_r is the second root, ra_r the first
        p_we = 1'b1;
        if (rank_a_r > r_rdata) begin
          p_waddr = root_r;
          p_wdata = ra_r;
        end else begin
          p_waddr = ra_r;
          p_wdata = root_r;
          if ((rank_a_r == r_rdata) && (r_rdata != ufk_pkg::RANK_MAX)) begin
            r_we    = 1'b1;
            r_waddr = root_r;
            r_wdata = r_rdata + 1'b1;
          end
        end
        cost_add                = 1'b1;
        out_valid_nxt           = 1'b1;
        out_data_nxt.edge_taken = 1'b1;
        out_data_nxt.tree_cost  = cost_sum;
        state_nxt               = S_IDLE;
      end

      S_SPARE: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    which_r    <= which_nxt;
    cur_r      <= cur_nxt;
    root_r     <= root_nxt;
    ra_r       <= ra_nxt;
    rank_a_r   <= rank_a_nxt;
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/ufk_check.sv
// ---------------------------------------------------------------------------
// ufk_check
// port-level checks of the kruskal edge filter, bound to the top level
// ---------------------------------------------------------------------------
module ufk_check (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input ufk_pkg::in_word_t  in_data,
  input logic               out_valid,
  input ufk_pkg::out_word_t out_data
);

  // reset starts the clearing sweep
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  // an accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  // result strobed only once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside end of work");

  // result words are never strobed back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind union_find_kruskal_edge_filter ufk_check u_ufk_check (.*);
